>>> sv/assert_macros.svh
// assertion macros used by the allocator rtl
// no dependencies; define SYNTHESIS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/ffba_pkg.sv
// types, codes and address helper for the first-fit block allocator
// no dependencies
package ffba_pkg;

    // address arithmetic width of the user address
    localparam int ADDR_BITS = 32;
    localparam logic [31:0] USER_MASK = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF :
                                        32'((64'd1 << ADDR_BITS) - 64'd1);

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NOOP = 2'd1,
        ST_OOM  = 2'd2,
        ST_BAD  = 2'd3
    } t_status;

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        CFG_HEAP_BASE    = 2'd0,
        CFG_HEAP_LIMIT   = 2'd1,
        CFG_HEADER_BYTES = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] heap_base;
        logic [31:0] heap_limit;
        logic [7:0]  header_bytes;
    } t_cfg;

    // one block table entry
    typedef struct packed {
        logic [31:0] start;
        logic [31:0] size;
        logic        free;
    } t_entry;

    // off = heap_base + header_bytes, start = block offset
    function automatic logic [31:0] f_user_addr(logic [32:0] off, logic [31:0] start);
        logic [33:0] sum;
        sum = {1'b0, off} + {2'b00, start};
        return sum[31:0] & USER_MASK;
    endfunction

endpackage

>>> sv/ffba_ram.sv
// block table memory: one write port, one registered read port
// depends on ffba_pkg for the entry type
module ffba_ram
    import ffba_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_entry           i_wdata,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_entry           o_rd_data
);

    t_entry mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/ffba_ctrl.sv
// request sequencer: scans the block table, updates it and holds the result
// depends on ffba_pkg and assert_macros.svh; drives ffba_ram
`include "assert_macros.svh"

module ffba_ctrl
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS = 64,
    localparam int IDX_W = $clog2(MAX_BLOCKS),
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_kind,
    input  logic [31:0]      i_request_size,
    input  logic [31:0]      i_free_address,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [31:0]      o_result_address,
    output t_status          o_status,
    output logic             o_we,
    output logic [IDX_W-1:0] o_waddr,
    output t_entry           o_wdata,
    output logic             o_rd_en,
    output logic [IDX_W-1:0] o_rd_addr,
    input  t_entry           i_rd_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_FALL = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    t_kind            r_kind;
    logic [31:0]      r_req;
    logic [31:0]      r_faddr;
    logic [32:0]      r_off;
    logic [32:0]      r_need;
    logic [IDX_W-1:0] r_chk, n_chk;
    logic [CNT_W-1:0] r_count, n_count;
    logic [31:0]      r_heap_top, n_heap_top;
    logic [31:0]      r_res_addr, n_res_addr;
    t_status          r_res_status, n_res_status;
    logic             r_out_valid;
    logic [31:0]      r_out_addr;
    t_status          r_out_status;

    logic        accept;
    logic        zero_req;
    logic [31:0] cand_addr;
    logic        hit;
    logic        last;
    logic [33:0] top_sum;
    logic        fits;
    logic        room;
    logic        slot_free;

    assign o_ready   = (r_state == S_IDLE);
    assign accept    = i_valid && o_ready;
    assign zero_req  = (t_kind'(i_kind) == KIND_ALLOC) ? (i_request_size == 32'd0)
                                                       : (i_free_address == 32'd0);
    assign cand_addr = f_user_addr(r_off, i_rd_data.start);
    assign hit       = (r_kind == KIND_ALLOC) ? (i_rd_data.free && i_rd_data.size >= r_req)
                                              : (cand_addr == r_faddr);
    assign last      = ((CNT_W'(r_chk) + CNT_W'(1)) == r_count);
    assign top_sum   = {2'b00, r_heap_top} + {1'b0, r_need};
    assign fits      = (top_sum <= {2'b00, i_cfg.heap_limit});
    assign room      = (r_count != CNT_W'(MAX_BLOCKS));
    assign slot_free = !r_out_valid || i_ready;

    always_comb begin
        n_state      = r_state;
        n_chk        = r_chk;
        n_count      = r_count;
        n_heap_top   = r_heap_top;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        o_we         = 1'b0;
        o_waddr      = r_chk;
        o_wdata      = i_rd_data;
        o_rd_en      = 1'b0;
        o_rd_addr    = r_chk;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (zero_req) begin
                        n_res_addr   = 32'd0;
                        n_res_status = ST_NOOP;
                        n_state      = S_DONE;
                    end else if (r_count == '0) begin
                        n_state = S_FALL;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = '0;
                        n_chk     = '0;
                        n_state   = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_state    = S_DONE;
                    n_res_addr = 32'd0;
                    if (r_kind == KIND_ALLOC) begin
                        o_we         = 1'b1;
                        o_wdata.free = 1'b0;
                        n_res_addr   = cand_addr;
                        n_res_status = ST_OK;
                    end else if (!i_rd_data.free) begin
                        o_we         = 1'b1;
                        o_wdata.free = 1'b1;
                        n_res_status = ST_OK;
                    end else begin
                        // double free
                        n_res_status = ST_BAD;
                    end
                end else if (last) begin
                    n_state = S_FALL;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_chk + IDX_W'(1);
                    n_chk     = r_chk + IDX_W'(1);
                end
            end
            S_FALL: begin
                n_state    = S_DONE;
                n_res_addr = 32'd0;
                if (r_kind == KIND_FREE) begin
                    n_res_status = ST_BAD;
                end else if (room && fits) begin
                    // append a new block at heap top
                    o_we          = 1'b1;
                    o_waddr       = r_count[IDX_W-1:0];
                    o_wdata.start = r_heap_top;
                    o_wdata.size  = r_req;
                    o_wdata.free  = 1'b0;
                    n_count       = r_count + CNT_W'(1);
                    n_heap_top    = top_sum[31:0];
                    n_res_addr    = f_user_addr(r_off, r_heap_top);
                    n_res_status  = ST_OK;
                end else begin
                    n_res_status = ST_OOM;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_heap_top  <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_heap_top <= n_heap_top;
            if (r_state == S_DONE && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk        <= n_chk;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        if (accept) begin
            r_kind  <= t_kind'(i_kind);
            r_req   <= i_request_size;
            r_faddr <= i_free_address;
            r_off   <= {1'b0, i_cfg.heap_base} + {25'd0, i_cfg.header_bytes};
            r_need  <= {25'd0, i_cfg.header_bytes} + {1'b0, i_request_size};
        end
        if (r_state == S_DONE && slot_free) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_res_status;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_result_address = r_out_addr;
    assign o_status         = r_out_status;

    `ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_BLOCKS))
    `ASSERT_IMPL(a_scan_in_table, i_clk, i_rst_n, r_state == S_SCAN, CNT_W'(r_chk) < r_count)
    `ASSERT_IMPL(a_write_state, i_clk, i_rst_n, o_we, r_state == S_SCAN || r_state == S_FALL)
    `ASSERT_NEXT(a_top_grows, i_clk, i_rst_n, r_state == S_FALL && o_we, r_heap_top > $past(r_heap_top))
    `ASSERT_NEXT(a_count_step, i_clk, i_rst_n, 1'b1, r_count == $past(r_count) || r_count == $past(r_count) + CNT_W'(1))

endmodule

>>> sv/first_fit_block_allocator_core.sv
// First-fit block allocator. Allocate requests reuse the lowest-numbered free block
// that is large enough (no splitting) or append a new block at heap top; free requests
// mark the block whose user address matches. The block table sits in one synchronous
// memory with a single read port, scanned one entry per cycle. A request that hits
// goes from the scan state to the done state; one that examines every entry without
// a hit, or meets an empty table, passes through the fallback state first (append
// or error); a zero-size allocate or a null free goes straight to the done state. A
// finished result moves to the output register only once that register is empty or
// being read, so a stalled result adds its wait to the next request. One request is
// in flight at a time; the next one is taken the cycle after a result reaches the
// output register, while that result waits there. No clearing pass runs after reset.
// Configuration writes are meant for idle periods.
// depends on ffba_pkg, ffba_ram, ffba_ctrl
module first_fit_block_allocator_core
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [31:0] i_request_size,
    input  logic [31:0] i_free_address,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_result_address,
    output logic [1:0]  o_status
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);

    t_cfg             r_cfg;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_entry           ram_wdata;
    logic             ram_rd_en;
    logic [IDX_W-1:0] ram_rd_addr;
    t_entry           ram_rd_data;
    t_status          status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.heap_base    <= 32'd0;
            r_cfg.heap_limit   <= 32'd65536;
            r_cfg.header_bytes <= 8'd24;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_HEAP_BASE:    r_cfg.heap_base    <= i_cfg_wdata;
                CFG_HEAP_LIMIT:   r_cfg.heap_limit   <= i_cfg_wdata;
                CFG_HEADER_BYTES: r_cfg.header_bytes <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    ffba_ram #(
        .DEPTH (MAX_BLOCKS),
        .IDX_W (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    ffba_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_kind           (i_kind),
        .i_request_size   (i_request_size),
        .i_free_address   (i_free_address),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_result_address (o_result_address),
        .o_status         (status),
        .o_we             (ram_we),
        .o_waddr          (ram_waddr),
        .o_wdata          (ram_wdata),
        .o_rd_en          (ram_rd_en),
        .o_rd_addr        (ram_rd_addr),
        .i_rd_data        (ram_rd_data)
    );

    assign o_status = status;

endmodule

>>> sim/ffba_checker.sv
// checker for the first-fit block allocator: watches the register, request and result
// ports, predicts every result from its own copy of the block table and compares it
// depends on ffba_pkg
module ffba_checker
    import ffba_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic        i_kind,
    input  logic [31:0] i_request_size,
    input  logic [31:0] i_free_address,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [31:0] i_result_address,
    input  logic [1:0]  i_status,
    output int          o_mismatches,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] address;
        t_status     status;
    } t_reply;

    logic [31:0] base_reg;
    logic [31:0] limit_reg;
    logic [7:0]  hdr_reg;

    logic [31:0] blk_start [TABLE_DEPTH];
    logic [31:0] blk_size  [TABLE_DEPTH];
    bit          blk_free  [TABLE_DEPTH];
    int          n_blocks;
    logic [31:0] heap_top;

    t_reply replies_due[$];
    int     n_bad = 0;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    // user address wraps at 32 bits
    function automatic logic [31:0] block_address(int idx);
        return base_reg + blk_start[idx] + 32'(hdr_reg);
    endfunction

    function automatic t_reply serve_request(t_kind kind, logic [31:0] req, logic [31:0] faddr);
        t_reply r;
        bit     hit;
        r.address = '0;
        r.status  = ST_OK;
        hit       = 1'b0;
        if (kind == KIND_ALLOC) begin
            if (req == '0) begin
                r.status = ST_NOOP;
            end else begin
                for (int i = 0; i < n_blocks; i++) begin
                    if (!hit && blk_free[i] && blk_size[i] >= req) begin
                        blk_free[i] = 1'b0;
                        r.address   = block_address(i);
                        hit         = 1'b1;
                    end
                end
                if (!hit) begin
                    // append check is done without wrap
                    if (n_blocks < TABLE_DEPTH &&
                        64'(heap_top) + 64'(hdr_reg) + 64'(req) <= 64'(limit_reg)) begin
                        blk_start[n_blocks] = heap_top;
                        blk_size[n_blocks]  = req;
                        blk_free[n_blocks]  = 1'b0;
                        r.address           = block_address(n_blocks);
                        heap_top            = heap_top + 32'(hdr_reg) + req;
                        n_blocks++;
                    end else begin
                        r.status = ST_OOM;
                    end
                end
            end
        end else if (faddr == '0) begin
            r.status = ST_NOOP;
        end else begin
            r.status = ST_BAD;
            for (int i = 0; i < n_blocks; i++) begin
                if (!hit && block_address(i) == faddr) begin
                    hit = 1'b1;
                    if (!blk_free[i]) begin
                        blk_free[i] = 1'b1;
                        r.status    = ST_OK;
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_reply want;
        if (!i_rst_n) begin
            base_reg  = '0;
            limit_reg = 32'd65536;
            hdr_reg   = 8'd24;
            n_blocks  = 0;
            heap_top  = '0;
            replies_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HEAP_BASE:    base_reg  = i_cfg_wdata;
                    CFG_HEAP_LIMIT:   limit_reg = i_cfg_wdata;
                    CFG_HEADER_BYTES: hdr_reg   = i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: result with no request waiting, address %h status %0d",
                             $time, i_result_address, i_status);
                    n_bad++;
                end else begin
                    want = replies_due.pop_front();
                    if (i_result_address !== want.address) begin
                        $display("%0t: result_address expected %h got %h",
                                 $time, want.address, i_result_address);
                        n_bad++;
                    end
                    if (i_status !== want.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, i_status);
                        n_bad++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                replies_due.push_back(serve_request(t_kind'(i_kind), i_request_size,
                                                    i_free_address));
            end
        end
        o_mismatches  <= n_bad;
        o_outstanding <= replies_due.size();
    end

endmodule

>>> sim/tb.sv
// top of the first-fit allocator testbench: clock, reset, register writes and requests
// depends on ffba_pkg, first_fit_block_allocator_core and ffba_checker
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ffba_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int PHASE_ITEMS = 72;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic [1:0]  i_cfg_index    = '0;
    logic [31:0] i_cfg_wdata    = '0;
    logic        i_valid        = 1'b0;
    logic        o_ready;
    logic        i_kind         = 1'b0;
    logic [31:0] i_request_size = '0;
    logic [31:0] i_free_address = '0;
    logic        o_valid;
    logic        i_ready        = 1'b0;
    logic [31:0] o_result_address;
    logic [1:0]  o_status;

    int n_mismatches;
    int n_outstanding;

    bit          calm     = 1'b0;
    logic [31:0] cur_base = '0;
    logic [7:0]  cur_hdr  = 8'd24;

    // offsets of blocks held by the stimulus, and of blocks it already released
    logic [31:0] live_offsets[$];
    logic [31:0] freed_offsets[$];
    t_kind       kinds_in_flight[$];

    first_fit_block_allocator_core #(
        .MAX_BLOCKS(TABLE_DEPTH)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_kind          (i_kind),
        .i_request_size  (i_request_size),
        .i_free_address  (i_free_address),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_result_address(o_result_address),
        .o_status        (o_status)
    );

    ffba_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_req_valid     (i_valid),
        .i_req_ready     (o_ready),
        .i_kind          (i_kind),
        .i_request_size  (i_request_size),
        .i_free_address  (i_free_address),
        .i_rsp_valid     (o_valid),
        .i_rsp_ready     (i_ready),
        .i_result_address(o_result_address),
        .i_status        (o_status),
        .o_mismatches    (n_mismatches),
        .o_outstanding   (n_outstanding)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= calm || ($urandom_range(99) >= 10);
        end
    end

    // remember which blocks were handed out so later frees can hit them
    always @(posedge i_clk) begin : track_blocks
        t_kind k;
        if (i_rst_n) begin
            if (o_valid && i_ready && kinds_in_flight.size() != 0) begin
                k = kinds_in_flight.pop_front();
                if (k == KIND_ALLOC && o_status == ST_OK) begin
                    live_offsets.push_back(o_result_address - cur_base - 32'(cur_hdr));
                end
            end
            if (i_valid && o_ready) begin
                kinds_in_flight.push_back(t_kind'(i_kind));
            end
        end
    end

    task automatic offer(t_kind k, logic [31:0] size, logic [31:0] faddr);
        while (!calm && $urandom_range(99) < 10) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_kind         <= k;
        i_request_size <= size;
        i_free_address <= faddr;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (n_outstanding != 0);
    endtask

    task automatic load_config(logic [31:0] base, logic [31:0] limit, logic [7:0] hdr);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_HEAP_BASE;
        i_cfg_wdata <= base;
        @(posedge i_clk);
        i_cfg_index <= CFG_HEAP_LIMIT;
        i_cfg_wdata <= limit;
        @(posedge i_clk);
        // upper bits of the header write are don't-care
        i_cfg_index <= CFG_HEADER_BYTES;
        i_cfg_wdata <= {24'($urandom), hdr};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_base = base;
        cur_hdr  = hdr;
    endtask

    function automatic logic [31:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 32'($urandom_range(64, 1));
        if (r < 85) return 32'($urandom_range(4096, 65));
        if (r < 95) return 32'($urandom_range(1 << 20, 4097));
        return $urandom;
    endfunction

    task automatic random_request();
        int          r;
        int          idx;
        logic [31:0] off;
        r = $urandom_range(99);
        if (live_offsets.size() != 0 && r < 35) begin
            idx = $urandom_range(live_offsets.size() - 1);
            off = live_offsets[idx];
            live_offsets.delete(idx);
            freed_offsets.push_back(off);
            offer(KIND_FREE, $urandom, cur_base + off + 32'(cur_hdr));
        end else if (freed_offsets.size() != 0 && r < 40) begin
            // usually a double free, sometimes a block that was handed out again
            off = freed_offsets[$urandom_range(freed_offsets.size() - 1)];
            offer(KIND_FREE, $urandom, cur_base + off + 32'(cur_hdr));
        end else if (r < 44) begin
            offer(KIND_FREE, $urandom, $urandom);
        end else if (r < 46) begin
            offer(KIND_FREE, $urandom, '0);
        end else if (r < 49) begin
            offer(KIND_ALLOC, '0, $urandom);
        end else begin
            offer(KIND_ALLOC, pick_size(), $urandom);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: base 0, limit 65536, 24 header bytes
        offer(KIND_ALLOC, '0, 32'hFFFF_FFFF);
        offer(KIND_FREE, 32'hFFFF_FFFF, '0);
        offer(KIND_FREE, '0, 32'hFFFF_FFFF);
        offer(KIND_ALLOC, 32'hFFFF_FFFF, '0);
        offer(KIND_ALLOC, 32'd65513, '0);
        offer(KIND_ALLOC, 32'd65512, '0);
        offer(KIND_ALLOC, 32'd1, '0);
        offer(KIND_FREE, '0, 32'd24);
        offer(KIND_FREE, '0, 32'd24);
        offer(KIND_FREE, '0, 32'd25);
        offer(KIND_ALLOC, 32'd65512, '0);
        offer(KIND_FREE, '0, 32'd24);
        offer(KIND_ALLOC, 32'd65513, '0);
        offer(KIND_ALLOC, 32'd1, '0);
        drain();
        // only the first block is held at this point
        live_offsets.delete();
        live_offsets.push_back('0);

        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: load_config(32'hFFFF_FF00, 32'hFFFF_FFFF, 8'd255);
                1: load_config('0, '0, '0);
                2: load_config(32'h1000_0000, 32'h0010_0000, 8'd8);
                3: load_config($urandom, 32'hFFFF_FFFF, 8'($urandom_range(255)));
                4: load_config('0, 32'd65536, 8'd24);
                5: load_config(32'hFFFF_FFFF, 32'h8000_0000, 8'd1);
                default: load_config($urandom, $urandom, 8'($urandom));
            endcase
            calm = (phase == 2);
            repeat (PHASE_ITEMS) random_request();
            drain();
        end

        repeat (70) @(posedge i_clk);
        if (n_mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/ffba_pkg.sv
sv/ffba_ram.sv
sv/ffba_ctrl.sv
sv/first_fit_block_allocator_core.sv
sim/ffba_checker.sv
sim/tb.sv
